>>> src/indexed_array_list_defines.svh
// Assertion macros for the indexed array list.
// Used by the top level only; clk_i and rst_ni must be in scope.
`ifndef INDEXED_ARRAY_LIST_DEFINES_SVH
`define INDEXED_ARRAY_LIST_DEFINES_SVH

`ifndef SYNTHESIS
`define IAL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("indexed_array_list: assertion failed");
`define IAL_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("indexed_array_list: forbidden condition seen");
`else
`define IAL_ASSERT(lbl, prop)
`define IAL_ASSERT_NEVER(lbl, cond)
`endif

`endif

>>> src/ial_pkg.sv
// Shared types and constants of the indexed array list.
// No dependencies; used by ial_ram and indexed_array_list.
`default_nettype none

package ial_pkg;

  localparam int DepthDef     = 256;
  localparam int DataWidthDef = 32;
  localparam int CapW         = 9;
  localparam int PosW         = 8;
  localparam int ValW         = 32;
  localparam int CountOutW    = 9;

  localparam logic [CapW-1:0] CapReset = 9'd256;

  typedef enum logic [2:0] {
    FN_READ      = 3'd0,
    FN_APPEND    = 3'd1,
    FN_INSERT    = 3'd2,
    FN_OVERWRITE = 3'd3,
    FN_DROP      = 3'd4,
    FN_REMOVE    = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    func_e                   func;
    logic [PosW-1:0]         position;
    logic signed [ValW-1:0]  value;
  } in_t;

  typedef struct packed {
    logic signed [ValW-1:0]  read_value;
    status_e                 status;
    logic [CountOutW-1:0]    count_after;
  } out_t;

endpackage

`default_nettype wire

>>> src/indexed_array_list.sv
// Indexed array list: bounded ordered list of words held in a RAM with registered read.
// Append, overwrite, drop, rejected cases and insert or remove at the tail go
// straight to the result; a read first waits for the RAM read data; an insert or
// remove that moves n entries (up to DEPTH - 1) first does one RAM read and one
// write-back per moved entry. One transaction is in work at a time; the next is taken
// the cycle after the result is loaded, and loading waits while out_stall_i is high.
// Reset empties the list and sets the limit to 256.
`default_nettype none
`include "indexed_array_list_defines.svh"

module indexed_array_list
  import ial_pkg::*;
#(
  parameter int DEPTH      = DepthDef,
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire in_t             in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output out_t                 out_data_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [CapW-1:0] cfg_data_i
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = (CW > CapW) ? CW : CapW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHIFT,
    S_DONE
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CapW-1:0]       cap_q, cap_d;
  logic [AW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [CW-1:0]         rem_q, rem_d;
  logic                  pend_q, pend_d;
  logic                  up_q, up_d;
  logic [AW-1:0]         pos_q, pos_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  status_e               rstat_q, rstat_d;
  logic [ValW-1:0]       rval_q, rval_d;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q, out_d;

  logic                  we, re;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;

  logic [WW-1:0]         cw, pw, lim, cap_w;
  logic                  full, accept;
  logic [63:0]           val_wide, rd_wide;
  logic [DATA_WIDTH-1:0] val_in;
  logic [ValW-1:0]       rd32;

  ial_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cw       = WW'(count_q);
  assign pw       = WW'(in_data_i.position);
  assign cap_w    = WW'(cap_q);
  assign lim      = (cap_w > WW'(DEPTH)) ? WW'(DEPTH) : cap_w;
  assign full     = (cw >= lim);
  assign val_wide = 64'($unsigned(in_data_i.value));
  assign val_in   = val_wide[DATA_WIDTH-1:0];
  assign rd_wide  = 64'(rdata);
  assign rd32     = rd_wide[ValW-1:0];

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cap_d       = cap_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    rem_d       = rem_q;
    pend_d      = pend_q;
    up_d        = up_q;
    pos_d       = pos_q;
    val_d       = val_q;
    rstat_d     = rstat_q;
    rval_d      = rval_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = pos_q;
    wdata       = val_q;
    re          = 1'b0;
    raddr       = rd_ptr_q;

    if (cfg_valid_i) begin
      cap_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rstat_d = ST_OK;
          rval_d  = '0;
          state_d = S_DONE;
          pos_d   = pw[AW-1:0];
          val_d   = val_in;
          unique case (in_data_i.func)
            FN_READ: begin
              if (pw < cw) begin
                re      = 1'b1;
                raddr   = pw[AW-1:0];
                state_d = S_READ;
              end else begin
                rstat_d = ST_RANGE;
              end
            end
            FN_APPEND: begin
              if (full) begin
                rstat_d = ST_FULL;
              end else begin
                we      = 1'b1;
                waddr   = cw[AW-1:0];
                wdata   = val_in;
                count_d = count_q + 1'b1;
              end
            end
            FN_INSERT: begin
              if (full) begin
                rstat_d = ST_FULL;
              end else if (pw > cw) begin
                rstat_d = ST_RANGE;
              end else if (pw == cw) begin
                we      = 1'b1;
                waddr   = pw[AW-1:0];
                wdata   = val_in;
                count_d = count_q + 1'b1;
              end else begin
                // move entries up from the tail, then place the word
                up_d     = 1'b1;
                rd_ptr_d = AW'(cw - 1'b1);
                rem_d    = CW'(cw - pw);
                pend_d   = 1'b0;
                state_d  = S_SHIFT;
              end
            end
            FN_OVERWRITE: begin
              if (pw < cw) begin
                we    = 1'b1;
                waddr = pw[AW-1:0];
                wdata = val_in;
              end else begin
                rstat_d = ST_RANGE;
              end
            end
            FN_DROP: begin
              if (count_q == '0) begin
                rstat_d = ST_EMPTY;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
            FN_REMOVE: begin
              if (count_q == '0) begin
                rstat_d = ST_EMPTY;
              end else if (pw >= cw) begin
                rstat_d = ST_RANGE;
              end else if (pw == cw - 1'b1) begin
                count_d = count_q - 1'b1;
              end else begin
                // move entries down from just above the hole
                up_d     = 1'b0;
                rd_ptr_d = AW'(pw + 1'b1);
                rem_d    = CW'(cw - pw - 1'b1);
                pend_d   = 1'b0;
                state_d  = S_SHIFT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        rval_d  = rd32;
        state_d = S_DONE;
      end
      S_SHIFT: begin
        if (pend_q) begin
          we    = 1'b1;
          waddr = wr_ptr_q;
          wdata = rdata;
        end
        if (rem_q != '0) begin
          re       = 1'b1;
          raddr    = rd_ptr_q;
          rd_ptr_d = up_q ? rd_ptr_q - 1'b1 : rd_ptr_q + 1'b1;
          wr_ptr_d = up_q ? rd_ptr_q + 1'b1 : rd_ptr_q - 1'b1;
          rem_d    = rem_q - 1'b1;
          pend_d   = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            // moves drained: close the gap or fill the hole
            if (up_q) begin
              we      = 1'b1;
              waddr   = pos_q;
              wdata   = val_q;
              count_d = count_q + 1'b1;
            end else begin
              count_d = count_q - 1'b1;
            end
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d.read_value  = rval_q;
          out_d.status      = rstat_q;
          out_d.count_after = CountOutW'(count_q);
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cap_q       <= CapReset;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cap_q       <= cap_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q <= rd_ptr_d;
    wr_ptr_q <= wr_ptr_d;
    rem_q    <= rem_d;
    up_q     <= up_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    rstat_q  <= rstat_d;
    rval_q   <= rval_d;
    out_q    <= out_d;
  end

  `IAL_ASSERT_NEVER(a_no_same_entry_rw, we && re && (waddr == raddr))
  `IAL_ASSERT(a_count_steps_by_one, !$stable(count_q) |->
    (count_q == $past(count_q) + 1'b1 || count_q == $past(count_q) - 1'b1))
  `IAL_ASSERT_NEVER(a_count_within_depth, WW'(count_q) > WW'(DEPTH))
  `IAL_ASSERT(a_result_from_done,
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == S_DONE))

endmodule

`default_nettype wire

>>> src/ial_ram.sv
// Word store of the indexed array list: one write port, one read port,
// registered read data. Depends on ial_pkg for default sizes.
`default_nettype none

module ial_ram
  import ial_pkg::*;
#(
  parameter int DEPTH      = DepthDef,
  parameter int DATA_WIDTH = DataWidthDef,
  parameter int AW         = $clog2(DEPTH)
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [AW-1:0]         waddr_i,
  input  wire logic [DATA_WIDTH-1:0] wdata_i,
  input  wire logic                  re_i,
  input  wire logic [AW-1:0]         raddr_i,
  output logic      [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> bench/indexed_array_list_tb.sv
// Self-checking testbench for the indexed array list (indexed_array_list).
// Depends on ial_pkg for the request/result structs, operation and status codes.
`timescale 1ns / 1ps

module indexed_array_list_tb;
  import ial_pkg::*;

  localparam int          CycleLimit  = 1_500_000;
  localparam int          LongHold    = 300;
  localparam int          DrainCycles = 300;
  localparam int          PrintLimit  = 40;
  localparam logic [2:0]  FnSpare0    = 3'd6;
  localparam logic [2:0]  FnSpare1    = 3'd7;
  localparam logic [ValW-1:0] MaxWord = 32'h7fff_ffff;
  localparam logic [ValW-1:0] MinWord = 32'h8000_0000;

  // Shadow copy of the list; predicts one reply per accepted request.
  class list_scoreboard;
    logic signed [ValW-1:0] shadow_words [DepthDef];
    int unsigned            shadow_count;
    int unsigned            shadow_limit;
    out_t                   replies_due [$];
    int unsigned            errors;
    int unsigned            requests;
    int unsigned            deepest;
    int unsigned            limit_writes;
    int unsigned            status_hits [4];

    function new();
      shadow_count = 0;
      shadow_limit = CapReset;
      errors       = 0;
      requests     = 0;
      deepest      = 0;
      limit_writes = 0;
      foreach (status_hits[k]) status_hits[k] = 0;
    endfunction

    function void set_limit(input logic [CapW-1:0] lim);
      shadow_limit = lim;
      limit_writes++;
    endfunction

    function void note_request(input in_t req);
      out_t        want;
      int unsigned pos;
      int unsigned lim;
      pos  = req.position;
      lim  = (shadow_limit > DepthDef) ? DepthDef : shadow_limit;
      want.read_value = '0;
      want.status     = ST_OK;
      case (req.func)
        FN_READ: begin
          if (pos < shadow_count) want.read_value = shadow_words[pos];
          else want.status = ST_RANGE;
        end
        FN_APPEND: begin
          if (shadow_count >= lim) begin
            want.status = ST_FULL;
          end else begin
            shadow_words[shadow_count] = req.value;
            shadow_count++;
          end
        end
        FN_INSERT: begin
          // full is checked before the position
          if (shadow_count >= lim) begin
            want.status = ST_FULL;
          end else if (pos > shadow_count) begin
            want.status = ST_RANGE;
          end else begin
            for (int i = shadow_count; i > pos; i--) shadow_words[i] = shadow_words[i-1];
            shadow_words[pos] = req.value;
            shadow_count++;
          end
        end
        FN_OVERWRITE: begin
          if (pos < shadow_count) shadow_words[pos] = req.value;
          else want.status = ST_RANGE;
        end
        FN_DROP: begin
          if (shadow_count == 0) want.status = ST_EMPTY;
          else shadow_count--;
        end
        FN_REMOVE: begin
          if (shadow_count == 0) begin
            want.status = ST_EMPTY;
          end else if (pos >= shadow_count) begin
            want.status = ST_RANGE;
          end else begin
            for (int i = pos; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
            shadow_count--;
          end
        end
        default: ;
      endcase
      want.count_after = shadow_count[CountOutW-1:0];
      replies_due.push_back(want);
      requests++;
      status_hits[want.status]++;
      if (shadow_count > deepest) deepest = shadow_count;
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= PrintLimit) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(input out_t got);
      out_t want;
      if (replies_due.size() == 0) begin
        report($sformatf("result with no request waiting: %h", got));
      end else begin
        want = replies_due.pop_front();
        if (got.read_value !== want.read_value)
          report($sformatf("read_value got %h want %h", got.read_value, want.read_value));
        if (got.status !== want.status)
          report($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.count_after !== want.count_after)
          report($sformatf("count_after got %0d want %0d", got.count_after, want.count_after));
      end
    endtask
  endclass

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  in_t             in_data_i   = '0;
  logic            out_stall_i = 1'b0;
  logic            cfg_valid_i = 1'b0;
  logic [CapW-1:0] cfg_data_i  = '0;
  logic            in_stall_o;
  logic            out_valid_o;
  out_t            out_data_o;
  logic            cfg_ready_o;

  list_scoreboard sb = new();
  int unsigned    cycle_count   = 0;
  bit             quiet         = 1'b0;
  bit             long_hold_due = 1'b0;

  indexed_array_list dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("[%0t] timeout, %0d replies outstanding", $realtime, sb.replies_due.size());
    $display("indexed_array_list_tb failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // Result side: random stall bursts, one long hold-off on request.
  initial begin : receiver
    int unsigned span;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      span = $urandom_range(1, 9);
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat (span) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  function automatic in_t make_request(input logic [2:0] fn, input int unsigned pos,
                                       input logic [ValW-1:0] val);
    in_t r;
    r.func     = func_e'(fn);
    r.position = PosW'(pos);
    r.value    = val;
    return r;
  endfunction

  // Mostly positions inside the list so operations reach the shifting paths.
  function automatic in_t random_request(input int unsigned grow_pct);
    in_t         r;
    int unsigned roll;
    int unsigned cnt;
    int unsigned hi;
    cnt  = sb.shadow_count;
    roll = $urandom_range(0, 99);
    if (roll < grow_pct)
      r.func = ($urandom_range(0, 1) != 0) ? FN_APPEND : FN_INSERT;
    else if (roll < grow_pct + (100 - grow_pct) / 3)
      r.func = ($urandom_range(0, 1) != 0) ? FN_READ : FN_OVERWRITE;
    else if (roll < 97)
      r.func = ($urandom_range(0, 1) != 0) ? FN_DROP : FN_REMOVE;
    else
      r.func = func_e'(($urandom_range(0, 1) != 0) ? FnSpare0 : FnSpare1);
    hi = (r.func == FN_INSERT) ? cnt : ((cnt == 0) ? 0 : cnt - 1);
    if (hi > 255) hi = 255;
    if ($urandom_range(0, 9) == 0) r.position = PosW'($urandom_range(0, 255));
    else r.position = PosW'($urandom_range(0, hi));
    case ($urandom_range(0, 11))
      0: r.value = MaxWord;
      1: r.value = MinWord;
      2: r.value = '0;
      3: r.value = '1;
      default: r.value = $urandom;
    endcase
    return r;
  endfunction

  task automatic send_request(input in_t req);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
  endtask

  // Drop valid and wait until every reply is back.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.replies_due.size() != 0);
  endtask

  task automatic write_limit(input logic [CapW-1:0] lim);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= lim;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_limit(lim);
  endtask

  task automatic run_phase(input int unsigned n, input int unsigned grow_pct);
    repeat (n) send_request(random_request(grow_pct));
  endtask

  task automatic fill_list();
    bit held;
    held = 1'b0;
    while (sb.shadow_count < DepthDef) begin
      // hold results off while the sender keeps offering
      if (!held && sb.shadow_count >= 100) begin
        long_hold_due = 1'b1;
        held          = 1'b1;
      end
      send_request(random_request(85));
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list corner cases
    send_request(make_request(FN_READ, 0, '0));
    send_request(make_request(FN_OVERWRITE, 0, '1));
    send_request(make_request(FN_DROP, 0, '0));
    send_request(make_request(FN_REMOVE, 0, '0));
    send_request(make_request(FN_INSERT, 1, '1));
    // build: -1, min, max, 0
    send_request(make_request(FN_INSERT, 0, MinWord));
    send_request(make_request(FN_APPEND, 255, MaxWord));
    send_request(make_request(FN_INSERT, 2, '0));
    send_request(make_request(FN_INSERT, 0, '1));
    for (int p = 0; p < 4; p++) send_request(make_request(FN_READ, p, '0));
    send_request(make_request(FN_READ, 255, '0));
    send_request(make_request(FN_OVERWRITE, 3, 32'h5a5a_a5a5));
    send_request(make_request(FN_OVERWRITE, 4, '0));
    send_request(make_request(FN_REMOVE, 4, '0));
    send_request(make_request(FN_REMOVE, 0, '0));
    send_request(make_request(FN_REMOVE, 2, '0));
    send_request(make_request(FN_READ, 1, '0));
    send_request(make_request(FnSpare0, 0, '1));
    send_request(make_request(FnSpare1, 255, '1));

    write_limit(9'd3);
    repeat (2) send_request(make_request(FN_APPEND, 0, $urandom));
    send_request(make_request(FN_APPEND, 0, '1));
    send_request(make_request(FN_INSERT, 255, '1));
    // limit below the count: entries stay readable
    write_limit(9'd1);
    send_request(make_request(FN_READ, 2, '0));
    send_request(make_request(FN_APPEND, 0, '1));
    write_limit(9'd0);
    send_request(make_request(FN_INSERT, 0, '1));
    send_request(make_request(FN_DROP, 0, '0));

    write_limit(9'd256);
    fill_list();
    run_phase(20, 90);
    run_phase(250, 5);
    write_limit(9'd16);
    run_phase(250, 45);
    write_limit(9'd1);
    run_phase(60, 45);
    write_limit(9'd511);
    run_phase(120, 50);
    repeat (2) begin
      write_limit(CapW'($urandom_range(1, 256)));
      run_phase(100, 50);
    end
    write_limit(9'd0);
    run_phase(30, 45);
    write_limit(9'd256);
    quiet = 1'b1;
    run_phase(160, 50);

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.replies_due.size() != 0)
      sb.report($sformatf("%0d replies never arrived", sb.replies_due.size()));
    $display("Ran %0d requests in %0d cycles over %0d limit settings, list depth up to %0d.",
             sb.requests, cycle_count, sb.limit_writes, sb.deepest);
    $display("Replies: %0d ok, %0d out of range, %0d full, %0d empty; %0d mismatches.",
             sb.status_hits[ST_OK], sb.status_hits[ST_RANGE], sb.status_hits[ST_FULL],
             sb.status_hits[ST_EMPTY], sb.errors);
    if (sb.errors == 0) $display("indexed_array_list_tb passed");
    else $display("indexed_array_list_tb failed");
    $finish;
  end

endmodule
